FILE: design/gbcm_pkg.sv
// Shared types, register map, S-box table and round function for the GOST block cipher.
package gbcm_pkg;

    localparam int unsigned BLK_W   = 64;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned ROUNDS  = 32;
    localparam int unsigned CNT_W   = $clog2(ROUNDS);
    localparam int unsigned ROT_AMT = 11;
    localparam int unsigned ADDR_W  = 6;
    localparam int unsigned IDX_W   = 3;

    // Register indexes (byte address = 8 * index)
    localparam logic [IDX_W-1:0] CFG_KEY01 = 3'd0;
    localparam logic [IDX_W-1:0] CFG_KEY23 = 3'd1;
    localparam logic [IDX_W-1:0] CFG_KEY45 = 3'd2;
    localparam logic [IDX_W-1:0] CFG_KEY67 = 3'd3;
    localparam logic [IDX_W-1:0] CFG_MODE  = 3'd4;
    localparam logic [IDX_W-1:0] CFG_DIR   = 3'd5;
    localparam logic [IDX_W-1:0] CFG_IV    = 3'd6;

    // Chaining mode codes; unused codes fall back to ECB
    localparam logic [2:0] MODE_ECB  = 3'd0;
    localparam logic [2:0] MODE_CBC  = 3'd1;
    localparam logic [2:0] MODE_PCBC = 3'd2;
    localparam logic [2:0] MODE_CFB  = 3'd3;
    localparam logic [2:0] MODE_OFB  = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    typedef logic [3:0] t_sbox [8][16];

    localparam t_sbox SBOX = '{
        '{4'hF, 4'hC, 4'h2, 4'hA, 4'h6, 4'h4, 4'h5, 4'h0,
          4'h7, 4'h9, 4'hE, 4'hD, 4'h1, 4'hB, 4'h8, 4'h3},
        '{4'hB, 4'h6, 4'h3, 4'h4, 4'hC, 4'hF, 4'hE, 4'h2,
          4'h7, 4'hD, 4'h8, 4'h0, 4'h5, 4'hA, 4'h9, 4'h1},
        '{4'h1, 4'hC, 4'hB, 4'h0, 4'hF, 4'hE, 4'h6, 4'h5,
          4'hA, 4'hD, 4'h4, 4'h8, 4'h9, 4'h3, 4'h7, 4'h2},
        '{4'h1, 4'h5, 4'hE, 4'hC, 4'hA, 4'h7, 4'h0, 4'hD,
          4'h6, 4'h2, 4'hB, 4'h4, 4'h9, 4'h3, 4'hF, 4'h8},
        '{4'h0, 4'hC, 4'h8, 4'h9, 4'hD, 4'h2, 4'hA, 4'hB,
          4'h7, 4'h3, 4'h6, 4'h5, 4'h4, 4'hE, 4'hF, 4'h1},
        '{4'h8, 4'h0, 4'hF, 4'h3, 4'h2, 4'h5, 4'hE, 4'hB,
          4'h1, 4'hA, 4'h4, 4'h7, 4'hC, 4'h9, 4'hD, 4'h6},
        '{4'h3, 4'h0, 4'h6, 4'hF, 4'h1, 4'hE, 4'h9, 4'h2,
          4'hD, 4'h8, 4'hC, 4'h4, 4'hB, 4'hA, 4'h5, 4'h7},
        '{4'h1, 4'hA, 4'h6, 4'h8, 4'hF, 4'hB, 4'h0, 4'h4,
          4'hC, 4'h3, 4'h5, 4'h9, 4'h7, 4'hD, 4'h2, 4'hE}
    };

    // Substitute each nibble through its own S-box, then rotate left
    function automatic logic [WORD_W-1:0] round_fn(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] s;
        s = '0;
        for (int n = 0; n < 8; n++) begin
            s[4*n +: 4] = SBOX[n][x[4*n +: 4]];
        end
        return {s[WORD_W-ROT_AMT-1:0], s[WORD_W-1:WORD_W-ROT_AMT]};
    endfunction

endpackage

FILE: design/gost_block_cipher_modes.sv
// GOST 28147-89 block cipher with ECB, CBC, PCBC, CFB and OFB chaining.
//
// One 64-bit block per transaction, bits 31:0 being the L half. A single round
// unit (key add, S-box substitution, rotate) is reused for all 32 Feistel rounds,
// one round per clock, stepped by a 5-bit round counter. An accepted block runs
// all its rounds, then a final step applies the chaining mode and loads the
// output register, waiting while that register still holds an unaccepted
// result; only then does the sequencer return to idle and take the next block.
// The result sits in an output register, so a waiting result does not block
// input until the following block finishes its rounds. Configuration is a 64-bit
// APB-style port, register i at byte address 8*i; write it only while idle.
// start_of_message reloads the chaining value from the IV register.
module gost_block_cipher_modes (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_data_in,
    input  logic        i_start_of_message,
    input  logic        i_last_block,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_data_out,
    output logic        o_last_block_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int unsigned W  = gbcm_pkg::WORD_W;
    localparam int unsigned BW = gbcm_pkg::BLK_W;
    localparam int unsigned CW = gbcm_pkg::CNT_W;

    // Configuration registers
    logic [W-1:0]  r_key [8];
    logic [2:0]    r_mode;
    logic          r_dir;
    logic [BW-1:0] r_iv;

    // Sequencer and datapath
    gbcm_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W-1:0]  r_l, n_l, r_r, n_r;
    logic          r_dec, n_dec;
    logic [BW-1:0] r_din, n_din;
    logic          r_last, n_last;
    logic [BW-1:0] r_chain, n_chain;
    logic          r_out_valid, n_out_valid;
    logic [BW-1:0] r_out, n_out;
    logic          r_out_last, n_out_last;

    logic                     wr_en;
    logic [gbcm_pkg::IDX_W-1:0] wr_idx;
    logic                     in_acc, out_acc;
    logic [BW-1:0]            cv_eff, core_in;
    logic                     core_dec;
    logic [2:0]               kidx;
    logic [W-1:0]             rnd_t;
    logic [BW-1:0]            core_res;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign wr_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) begin
                r_key[k] <= '0;
            end
            r_mode <= gbcm_pkg::MODE_ECB;
            r_dir  <= 1'b0;
            r_iv   <= '0;
        end else if (wr_en) begin
            case (wr_idx)
                gbcm_pkg::CFG_KEY01: begin
                    r_key[0] <= pwdata[31:0];
                    r_key[1] <= pwdata[63:32];
                end
                gbcm_pkg::CFG_KEY23: begin
                    r_key[2] <= pwdata[31:0];
                    r_key[3] <= pwdata[63:32];
                end
                gbcm_pkg::CFG_KEY45: begin
                    r_key[4] <= pwdata[31:0];
                    r_key[5] <= pwdata[63:32];
                end
                gbcm_pkg::CFG_KEY67: begin
                    r_key[6] <= pwdata[31:0];
                    r_key[7] <= pwdata[63:32];
                end
                gbcm_pkg::CFG_MODE: r_mode <= pwdata[2:0];
                gbcm_pkg::CFG_DIR:  r_dir  <= pwdata[0];
                gbcm_pkg::CFG_IV:   r_iv   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (wr_idx)
            gbcm_pkg::CFG_KEY01: prdata = {r_key[1], r_key[0]};
            gbcm_pkg::CFG_KEY23: prdata = {r_key[3], r_key[2]};
            gbcm_pkg::CFG_KEY45: prdata = {r_key[5], r_key[4]};
            gbcm_pkg::CFG_KEY67: prdata = {r_key[7], r_key[6]};
            gbcm_pkg::CFG_MODE:  prdata = {61'd0, r_mode};
            gbcm_pkg::CFG_DIR:   prdata = {63'd0, r_dir};
            gbcm_pkg::CFG_IV:    prdata = r_iv;
            default:             prdata = '0;
        endcase
    end

    assign o_ready          = (r_state == gbcm_pkg::ST_IDLE);
    assign in_acc           = i_valid & o_ready;
    assign out_acc          = r_out_valid & i_ready;
    assign o_valid          = r_out_valid;
    assign o_data_out       = r_out;
    assign o_last_block_out = r_out_last;

    // Pick the core input and direction for the chaining mode
    assign cv_eff = i_start_of_message ? r_iv : r_chain;
    always_comb begin
        case (r_mode)
            gbcm_pkg::MODE_CBC, gbcm_pkg::MODE_PCBC: begin
                core_in  = r_dir ? i_data_in : (i_data_in ^ cv_eff);
                core_dec = r_dir;
            end
            gbcm_pkg::MODE_CFB, gbcm_pkg::MODE_OFB: begin
                core_in  = cv_eff;
                core_dec = 1'b0;
            end
            default: begin
                core_in  = i_data_in;
                core_dec = r_dir;
            end
        endcase
    end

    // Key schedule: encrypt runs 0..7 three times then 7..0, decrypt the reverse
    always_comb begin
        if (!r_dec) begin
            kidx = (r_cnt[4] & r_cnt[3]) ? ~r_cnt[2:0] : r_cnt[2:0];
        end else begin
            kidx = (r_cnt[4:3] == 2'b00) ? r_cnt[2:0] : ~r_cnt[2:0];
        end
    end

    assign rnd_t    = r_l ^ gbcm_pkg::round_fn(r_r + r_key[kidx]);
    assign core_res = {r_r, r_l};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_l         = r_l;
        n_r         = r_r;
        n_dec       = r_dec;
        n_din       = r_din;
        n_last      = r_last;
        n_chain     = r_chain;
        n_out_valid = r_out_valid & ~out_acc;
        n_out       = r_out;
        n_out_last  = r_out_last;
        case (r_state)
            gbcm_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = gbcm_pkg::ST_RUN;
                    n_cnt   = '0;
                    n_l     = core_in[W-1:0];
                    n_r     = core_in[BW-1:W];
                    n_dec   = core_dec;
                    n_din   = i_data_in;
                    n_last  = i_last_block;
                    n_chain = cv_eff;
                end
            end
            gbcm_pkg::ST_RUN: begin
                // No swap after the final round
                if (r_cnt == CW'(gbcm_pkg::ROUNDS - 1)) begin
                    n_l     = rnd_t;
                    n_state = gbcm_pkg::ST_FIN;
                end else begin
                    n_l = r_r;
                    n_r = rnd_t;
                end
                n_cnt = r_cnt + 1'b1;
            end
            gbcm_pkg::ST_FIN: begin
                // Hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_last  = r_last;
                    n_state     = gbcm_pkg::ST_IDLE;
                    case (r_mode)
                        gbcm_pkg::MODE_CBC: begin
                            if (r_dec) begin
                                n_out   = core_res ^ r_chain;
                                n_chain = r_din;
                            end else begin
                                n_out   = core_res;
                                n_chain = core_res;
                            end
                        end
                        gbcm_pkg::MODE_PCBC: begin
                            n_out   = r_dec ? (core_res ^ r_chain) : core_res;
                            n_chain = (r_dec ? (core_res ^ r_chain) : core_res) ^ r_din;
                        end
                        gbcm_pkg::MODE_CFB: begin
                            n_out   = r_din ^ core_res;
                            n_chain = r_dir ? r_din : (r_din ^ core_res);
                        end
                        gbcm_pkg::MODE_OFB: begin
                            n_out   = r_din ^ core_res;
                            n_chain = core_res;
                        end
                        default: n_out = core_res;
                    endcase
                end
            end
            default: n_state = gbcm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gbcm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_chain     <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_chain     <= n_chain;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l        <= n_l;
        r_r        <= n_r;
        r_dec      <= n_dec;
        r_din      <= n_din;
        r_last     <= n_last;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

`ifndef NO_ASSERTIONS
    // A new block always starts at round zero
    a_start_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == gbcm_pkg::ST_RUN) && (r_cnt == '0))
        else $error("round counter not cleared at block start");

    // Leaving the rounds only after the last one
    a_fin_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gbcm_pkg::ST_RUN) && (r_cnt != CW'(gbcm_pkg::ROUNDS - 1))
        |=> (r_state == gbcm_pkg::ST_RUN))
        else $error("round loop exited early");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> $stable(r_out) && r_out_valid)
        else $error("stalled result changed");
`endif

endmodule

FILE: bench/gost_block_cipher_modes_tb.sv
// Self-checking testbench for the GOST block cipher with chaining modes.
module gost_block_cipher_modes_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned ROT_LEFT    = 11;
    localparam logic [gbcm_pkg::IDX_W-1:0] CFG_UNUSED = 3'd7;

    // S-box rows, entry k in nibble k
    localparam logic [7:0][63:0] SUBST = {
        64'hE2D7_953C_40BF_86A1, 64'h75AB_4C8D_29E1_F603,
        64'h6D9C_74A1_BE52_3F08, 64'h1FE4_5637_BA2D_98C0,
        64'h8F39_4B26_D07A_CE51, 64'h2739_84DA_56EF_0BC1,
        64'h19A5_08D7_2EFC_436B, 64'h38B1_DE97_0546_A2CF
    };

    typedef struct packed {
        logic [63:0] block;
        logic        last;
    } t_cipher_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_data_in = '0;
    logic        i_start_of_message = 1'b0;
    logic        i_last_block = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_data_out;
    logic        o_last_block_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    // Predictor state and configuration copy
    logic [31:0] key_word [8];
    logic [2:0]  mode_reg;
    logic        decrypt_reg;
    logic [63:0] iv_reg;
    logic [63:0] chain_reg;

    t_cipher_result pending_results [$];

    int err_cnt    = 0;
    int cycle_cnt  = 0;
    int items_sent = 0;
    int gap_max    = 0;
    int burst_max  = 1;
    int burst_left = 1;
    int stall_pct  = 0;
    int stall_max  = 0;
    int hold_cnt   = 0;

    gost_block_cipher_modes dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_data_in          (i_data_in),
        .i_start_of_message (i_start_of_message),
        .i_last_block       (i_last_block),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_data_out         (o_data_out),
        .o_last_block_out   (o_last_block_out),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: random stalls of random length
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready  <= 1'b0;
        end else if (stall_max != 0 && $urandom_range(0, 99) < stall_pct) begin
            hold_cnt <= $urandom_range(0, stall_max - 1);
            i_ready  <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic logic [31:0] mix_word(input logic [31:0] x);
        logic [31:0] s;
        for (int n = 0; n < 8; n++) begin
            s[4*n +: 4] = SUBST[n][4*x[4*n +: 4] +: 4];
        end
        return (s << ROT_LEFT) | (s >> (32 - ROT_LEFT));
    endfunction

    function automatic logic [63:0] feistel(input logic [63:0] blk, input logic decrypt);
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] t;
        int k;
        l = blk[31:0];
        r = blk[63:32];
        for (int i = 0; i < 32; i++) begin
            if (!decrypt) begin
                k = (i < 24) ? (i % 8) : (31 - i);
            end else begin
                k = (i < 8) ? i : (7 - (i % 8));
            end
            t = l ^ mix_word(r + key_word[k]);
            if (i < 31) begin
                l = r;
                r = t;
            end else begin
                l = t;
            end
        end
        return {r, l};
    endfunction

    // Cipher one block under the current mode and advance the chaining value
    function automatic logic [63:0] cipher_block(input logic [63:0] d, input logic som);
        logic [63:0] res;
        if (som) chain_reg = iv_reg;
        case (mode_reg)
            gbcm_pkg::MODE_CBC: begin
                if (!decrypt_reg) begin
                    res = feistel(d ^ chain_reg, 1'b0);
                    chain_reg = res;
                end else begin
                    res = feistel(d, 1'b1) ^ chain_reg;
                    chain_reg = d;
                end
            end
            gbcm_pkg::MODE_PCBC: begin
                if (!decrypt_reg) res = feistel(d ^ chain_reg, 1'b0);
                else res = feistel(d, 1'b1) ^ chain_reg;
                chain_reg = res ^ d;
            end
            gbcm_pkg::MODE_CFB: begin
                res = d ^ feistel(chain_reg, 1'b0);
                chain_reg = decrypt_reg ? d : res;
            end
            gbcm_pkg::MODE_OFB: begin
                chain_reg = feistel(chain_reg, 1'b0);
                res = d ^ chain_reg;
            end
            default: res = feistel(d, decrypt_reg);
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("ERROR %0t: %s: expected %h, got %h", $time, what, want, got);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_cipher_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no transaction pending", '0, o_data_out);
            end else begin
                want = pending_results.pop_front();
                if (o_data_out !== want.block)
                    report_mismatch("data_out", want.block, o_data_out);
                if (o_last_block_out !== want.last)
                    report_mismatch("last_block_out", 64'(want.last), 64'(o_last_block_out));
            end
        end
    end

    task automatic write_reg(input logic [gbcm_pkg::IDX_W-1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            gbcm_pkg::CFG_KEY01: {key_word[1], key_word[0]} = value;
            gbcm_pkg::CFG_KEY23: {key_word[3], key_word[2]} = value;
            gbcm_pkg::CFG_KEY45: {key_word[5], key_word[4]} = value;
            gbcm_pkg::CFG_KEY67: {key_word[7], key_word[6]} = value;
            gbcm_pkg::CFG_MODE:  mode_reg = value[2:0];
            gbcm_pkg::CFG_DIR:   decrypt_reg = value[0];
            gbcm_pkg::CFG_IV:    iv_reg = value;
            default:   ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_block(input logic [63:0] data, input logic som, input logic last);
        logic [63:0] res;
        int gap;
        i_valid            <= 1'b1;
        i_data_in          <= data;
        i_start_of_message <= som;
        i_last_block       <= last;
        do @(posedge i_clk); while (!o_ready);
        res = cipher_block(data, som);
        pending_results.push_back('{res, last});
        items_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            burst_left = $urandom_range(1, burst_max);
            // keep valid up when there is no gap
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Hold the sender until every pending transaction has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_block();
        return {$urandom, $urandom};
    endfunction

    task automatic test_chain_after_reset();
        // chaining value is zero after reset, keys still zero
        write_reg(gbcm_pkg::CFG_MODE, 64'(gbcm_pkg::MODE_CBC));
        send_block(64'h0, 1'b0, 1'b0);
        send_block('1, 1'b0, 1'b1);
        drain_results();
    endtask

    task automatic test_modes_directed();
        logic [63:0] corner_data [4];
        int k;
        corner_data[0] = '0;
        corner_data[1] = '1;
        corner_data[2] = 64'h5555_5555_5555_5555;
        corner_data[3] = 64'hAAAA_AAAA_AAAA_AAAA;
        k = 0;
        write_reg(gbcm_pkg::CFG_KEY01, '1);
        write_reg(gbcm_pkg::CFG_KEY23, '1);
        write_reg(gbcm_pkg::CFG_KEY45, '1);
        write_reg(gbcm_pkg::CFG_KEY67, '1);
        write_reg(gbcm_pkg::CFG_IV, '1);
        // nothing lives at this index, the write must leave everything as is
        write_reg(CFG_UNUSED, rand_block());
        for (int m = 0; m < 5; m++) begin
            for (int d = 0; d < 2; d++) begin
                write_reg(gbcm_pkg::CFG_MODE, 64'(m));
                write_reg(gbcm_pkg::CFG_DIR, 64'(d));
                send_block(corner_data[k % 4], 1'b1, 1'b0);
                send_block(corner_data[(k + 1) % 4], 1'b0, 1'b1);
                k += 2;
                drain_results();
            end
        end
        // unused mode codes fall back to ECB
        for (int m = 5; m < 8; m++) begin
            write_reg(gbcm_pkg::CFG_MODE, 64'(m));
            send_block(rand_block(), m[0], m[1]);
            drain_results();
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int phase;
        int phase_end;
        int len;
        int r;
        logic [63:0] v;
        phase = 0;
        while (items_sent < n_items) begin
            drain_results();
            for (int idx = 0; idx < 7; idx++) begin
                if (phase == 0 || $urandom_range(0, 9) < 7) begin
                    r = $urandom_range(0, 7);
                    v = (r == 0) ? '0 : (r == 1) ? '1 : rand_block();
                    case (idx)
                        gbcm_pkg::CFG_MODE: begin
                            r = $urandom_range(0, 15);
                            v = (r < 14) ? 64'(r % 5) : 64'($urandom_range(5, 7));
                        end
                        gbcm_pkg::CFG_DIR: v = 64'($urandom_range(0, 1));
                        default: ;
                    endcase
                    write_reg(idx[gbcm_pkg::IDX_W-1:0], v);
                end
            end
            if (phase % 4 == 0) begin
                gap_max   = 0;
                burst_max = 1;
                stall_pct <= 0;
                stall_max <= 0;
            end else begin
                gap_max   = $urandom_range(1, 6);
                burst_max = $urandom_range(1, 8);
                stall_pct <= $urandom_range(5, 50);
                stall_max <= (phase % 4 == 3) ? 40 : $urandom_range(1, 6);
            end
            phase_end = items_sent + $urandom_range(60, 140);
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) < 85) begin
                    len = $urandom_range(1, 10);
                    for (int j = 0; j < len; j++) begin
                        send_block(rand_block(), j == 0, j == len - 1);
                    end
                end else begin
                    send_block(rand_block(), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                end
                if ((phase == 1 && items_sent + 30 > phase_end) || $urandom_range(0, 39) == 0)
                    drain_results();
            end
            phase++;
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 8; i++) key_word[i] = '0;
        mode_reg    = gbcm_pkg::MODE_ECB;
        decrypt_reg = 1'b0;
        iv_reg      = '0;
        chain_reg   = '0;
        @(posedge i_clk);

        test_chain_after_reset();
        test_modes_directed();
        test_random_traffic(items_sent + 1400);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0)
            report_mismatch("transactions never returned", '0, 64'(pending_results.size()));
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
design/gbcm_pkg.sv
design/gost_block_cipher_modes.sv
bench/gost_block_cipher_modes_tb.sv
